FILE: src/gated_average_pressure_convert_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clock and reset in the scope of each use.
`ifndef GATED_AVERAGE_PRESSURE_CONVERT_MACROS_SVH
`define GATED_AVERAGE_PRESSURE_CONVERT_MACROS_SVH

// Checked at every edge, reset included.
`define GAPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("gapc assertion failed");

// Checked outside reset only.
`define GAPC_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("gapc assertion failed");

`endif

FILE: src/gapc_pkg.sv
// Package for the gated average pressure converter: sizes, register
// indexes, sequencer states and the divider command/status structs.
`default_nettype none
package gapc_pkg;

   localparam int CHANNELS    = 4;
   localparam int CODE_W      = 16;
   localparam int CH_W        = 2;
   localparam int SUM_W       = 24;
   localparam int COUNT_W     = 9;
   localparam int SHIFT_W     = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_SHIFT   = 8;
   localparam int DIV_STEPS   = CODE_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [CODE_W-1:0] CODE_FULL = '1;

   localparam logic [CH_W-1:0]    RST_WATCHED   = '0;
   localparam logic [CODE_W-1:0]  RST_THRESHOLD = 16'd10000;
   localparam logic [CODE_W-1:0]  RST_OFFSET    = 16'd13100;
   localparam logic [CODE_W-1:0]  RST_DIVISOR   = 16'd874;
   localparam logic [SHIFT_W-1:0] RST_SHIFT     = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATCHED_CHANNEL = 3'd0,
      CSR_STORE_THRESHOLD = 3'd1,
      CSR_ZERO_OFFSET     = 3'd2,
      CSR_SCALE_DIVISOR   = 3'd3,
      CSR_AVERAGE_SHIFT   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVERAGE,
      ST_CONVERT,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CODE_W-1:0] dividend;
      logic [CODE_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [CODE_W-1:0] quotient;
   } div_sts_type;

endpackage
`default_nettype wire

FILE: src/gapc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on gapc_pkg. A zero divisor gives an all-ones quotient.
`default_nettype none
module gapc_div
   import gapc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_cmd_type cmd,
   output div_sts_type sts
);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CODE_W-1:0]    rem_ff, rem_in;
   logic [CODE_W-1:0]    quo_ff, quo_in;
   logic [CODE_W-1:0]    dsr_ff, dsr_in;
   logic [CODE_W:0]      trial;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[CODE_W-1]};
      fits      = trial >= {1'b0, dsr_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      if (cmd.start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = '0;
         quo_in    = cmd.dividend;
         dsr_in    = cmd.divisor;
      end else if (active_ff) begin
         rem_in = fits ? CODE_W'(trial - {1'b0, dsr_ff}) : trial[CODE_W-1:0];
         quo_in = {quo_ff[CODE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: src/gated_average_pressure_convert.sv
// Channel     | Ports                                      | Direction
// req         | req_valid/ready, req_sample_channel/code   | in
// rsp         | rsp_valid/ready, average/pressure/below    | out
// csr         | csr_valid/ready, csr_index, csr_data       | in (register write)
//
// A sample that does not close a block passes through idle (accept) and update.
// A closing sample then goes through average, convert and result; when the
// average is above the offset it also waits in divide for the serial divider.
// req_ready is low until the sequencer is back in idle; the result register
// lets the next sample in while a result waits on rsp_ready.
// Reset is synchronous; it clears held samples, sum and count and loads the register defaults.
// Top level of the gated average pressure converter; uses gapc_pkg, gapc_div.
`default_nettype none
module gated_average_pressure_convert
   import gapc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CH_W-1:0]      req_sample_channel,
   input  wire logic [CODE_W-1:0]    req_sample_code,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [CODE_W-1:0]         rsp_average_code,
   output logic [CODE_W-1:0]         rsp_pressure_value,
   output logic                      rsp_below_offset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CODE_W-1:0]    csr_data
);

   state_type state_ff, state_in;

   logic [CH_W-1:0]    watched_ff;
   logic [CODE_W-1:0]  threshold_ff;
   logic [CODE_W-1:0]  offset_ff;
   logic [CODE_W-1:0]  divisor_ff;
   logic [SHIFT_W-1:0] shift_ff;

   logic [CH_W-1:0]    item_ch_ff, item_ch_in;
   logic [CODE_W-1:0]  item_code_ff, item_code_in;
   logic [CODE_W-1:0]  held_ff [CHANNELS];
   logic [CODE_W-1:0]  held_in [CHANNELS];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0]  avg_ff, avg_in;
   logic [CODE_W-1:0]  press_ff, press_in;
   logic               below_ff, below_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [CODE_W-1:0]  rsp_press_ff, rsp_press_in;
   logic               rsp_below_ff, rsp_below_in;

   logic [SHIFT_W-1:0] shift_eff;
   logic [COUNT_W-1:0] target;
   logic               ch_ok;
   logic [CODE_W-1:0]  held_val;
   logic               take;
   logic [COUNT_W-1:0] count_inc;
   logic [SUM_W-1:0]   sum_inc;
   logic [SUM_W-1:0]   sum_shifted;

   div_cmd_type div_cmd;
   div_sts_type div_sts;

   gapc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign shift_eff   = (shift_ff > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift_ff;
   assign target      = COUNT_W'(1) << shift_eff;
   assign ch_ok       = int'(item_ch_ff) < CHANNELS;
   assign held_val    = (item_code_ff > threshold_ff) ? item_code_ff : held_ff[item_ch_ff];
   assign take        = ch_ok && (item_ch_ff == watched_ff)
                        && (held_val != '0) && (held_val != CODE_FULL);
   assign sum_inc     = sum_ff + SUM_W'(held_val);
   assign count_inc   = count_ff + 1'b1;
   assign sum_shifted = sum_ff >> shift_eff;

   always_comb begin
      state_in     = state_ff;
      item_ch_in   = item_ch_ff;
      item_code_in = item_code_ff;
      held_in      = held_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      press_in     = press_ff;
      below_in     = below_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_press_in = rsp_press_ff;
      rsp_below_in = rsp_below_ff;
      req_ready    = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = CODE_W'(avg_ff - offset_ff);
      div_cmd.divisor  = divisor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_ch_in   = req_sample_channel;
               item_code_in = req_sample_code;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
            if (ch_ok) begin
               held_in[item_ch_ff] = held_val;
            end
            if (take) begin
               sum_in   = sum_inc;
               count_in = count_inc;
               if (count_inc >= target) begin
                  state_in = ST_AVERAGE;
               end
            end
         end
         ST_AVERAGE: begin
            avg_in   = sum_shifted[CODE_W-1:0];
            sum_in   = '0;
            count_in = '0;
            state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (avg_ff > offset_ff) begin
               below_in      = 1'b0;
               div_cmd.start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               below_in = 1'b1;
               press_in = '0;
               state_in = ST_RESULT;
            end
         end
         ST_DIVIDE: begin
            if (div_sts.done) begin
               press_in = div_sts.quotient;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_press_in = press_ff;
               rsp_below_in = below_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            held_ff[i] <= '0;
         end
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ch_ff   <= item_ch_in;
      item_code_ff <= item_code_in;
      avg_ff       <= avg_in;
      press_ff     <= press_in;
      below_ff     <= below_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_press_ff <= rsp_press_in;
      rsp_below_ff <= rsp_below_in;
   end

   // register file; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         watched_ff   <= RST_WATCHED;
         threshold_ff <= RST_THRESHOLD;
         offset_ff    <= RST_OFFSET;
         divisor_ff   <= RST_DIVISOR;
         shift_ff     <= RST_SHIFT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WATCHED_CHANNEL: watched_ff   <= csr_data[CH_W-1:0];
            CSR_STORE_THRESHOLD: threshold_ff <= csr_data;
            CSR_ZERO_OFFSET:     offset_ff    <= csr_data;
            CSR_SCALE_DIVISOR:   divisor_ff   <= csr_data;
            CSR_AVERAGE_SHIFT:   shift_ff     <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_average_code   = rsp_avg_ff;
   assign rsp_pressure_value = rsp_press_ff;
   assign rsp_below_offset   = rsp_below_ff;

endmodule
`default_nettype wire

FILE: src/gapc_checker.sv
// Port-level checker for the gated average pressure converter, with its bind.
// Depends on gapc_pkg and the assertion macros header.
`default_nettype none
`include "gated_average_pressure_convert_macros.svh"
module gapc_checker
   import gapc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CODE_W-1:0] rsp_pressure_value,
   input wire logic              rsp_below_offset
);

   `GAPC_ASSERT(a_no_rsp_after_reset, reset |=> !rsp_valid)
   `GAPC_ASSERT_RST(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid)
   `GAPC_ASSERT_RST(a_below_zero, rsp_valid && rsp_below_offset |-> rsp_pressure_value == '0)
   `GAPC_ASSERT_RST(a_busy_after_req, req_valid && req_ready |=> !req_ready)
   `GAPC_ASSERT_RST(a_new_rsp_needs_req, !rsp_valid |=> !rsp_valid || !$past(req_ready))

endmodule

bind gated_average_pressure_convert gapc_checker u_gapc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_pressure_value (rsp_pressure_value),
   .rsp_below_offset   (rsp_below_offset)
);
`default_nettype wire
